// ----- rtl/core/assert_macros.svh -----
// Assertion helpers shared by the RTL. The checks sample on clk and are
// disabled while rst_n is low; both names must exist where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Condition holds at every sampled edge.
`define AST_CHECK(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define AST_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define AST_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define AST_CHECK(lbl, cond, msg)
`define AST_IMPLY(lbl, ante, cons, msg)
`define AST_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- rtl/core/arhp_pkg.sv -----
package arhp_pkg;

    typedef enum logic [2:0] {
        KIND_RECORD    = 3'd0,
        KIND_CLEAN     = 3'd1,
        KIND_BAD_MAGIC = 3'd2,
        KIND_TRUNC     = 3'd3,
        KIND_NEG_SIZE  = 3'd4
    } kind_t;

    localparam logic [7:0] MAGIC_0 = 8'h5E;  // '^'
    localparam logic [7:0] MAGIC_1 = 8'h6A;  // 'j'
    localparam logic [7:0] MAGIC_2 = 8'h61;  // 'a'
    localparam logic [7:0] MAGIC_3 = 8'h78;  // 'x'

    // Fixed part: stamp(8) mode(2) owner(2) group(2) size(8)
    localparam logic [4:0] FIXED_LAST = 5'd21;
    localparam logic [4:0] MODE_BASE  = 5'd8;
    localparam logic [4:0] OWNER_BASE = 5'd10;
    localparam logic [4:0] GROUP_BASE = 5'd12;
    localparam logic [4:0] SIZE_BASE  = 5'd14;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_LW    = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        kind_t              kind;
        logic [7:0]         entry_type;
        logic [15:0]        name_len;
        logic [15:0]        desc_len;
        logic signed [63:0] stamp;
        logic [15:0]        perm_mode;
        logic [15:0]        owner_id;
        logic [15:0]        group_id;
        logic [62:0]        data_size;
    } result_t;

    // Up to two results per accepted byte; first goes out before second.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    typedef struct packed {
        logic [FIFO_LW-1:0] level;
        logic               room;
    } fifo_status_t;

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] val;
        unique case (idx)
            2'd0:    val = MAGIC_0;
            2'd1:    val = MAGIC_1;
            2'd2:    val = MAGIC_2;
            default: val = MAGIC_3;
        endcase
        return val;
    endfunction

endpackage

// ----- rtl/core/arhp_parse.sv -----
module arhp_parse
    import arhp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] data_byte,
    input  logic       final_byte,
    output push_t      push
);

    typedef enum logic [3:0] {
        PH_MAGIC = 4'd0,
        PH_TYPE  = 4'd1,
        PH_NLEN  = 4'd2,
        PH_NAME  = 4'd3,
        PH_DLEN  = 4'd4,
        PH_DESC  = 4'd5,
        PH_FIXED = 4'd6,
        PH_DATA  = 4'd7,
        PH_ERR   = 4'd8
    } phase_t;

    phase_t      phase_reg, phase_next, phase_step;
    logic [62:0] cnt_reg, cnt_next;
    kind_t       err_reg, err_next;

    logic [7:0]  type_reg, type_next;
    logic [15:0] nlen_reg, nlen_next;
    logic [15:0] dlen_reg, dlen_next;
    logic [63:0] stamp_reg, stamp_next;
    logic [15:0] mode_reg, mode_next;
    logic [15:0] owner_reg, owner_next;
    logic [15:0] group_reg, group_next;
    logic [63:0] size_reg, size_next;

    logic [4:0]  fidx;
    logic [4:0]  sidx;
    logic [15:0] len_full;
    logic [63:0] size_full;
    logic        rec;
    kind_t       end_kind;
    result_t     rec_res, end_res;

    assign fidx      = cnt_reg[4:0];
    assign sidx      = fidx - SIZE_BASE;
    assign size_full = {data_byte, size_reg[55:0]};

    always_comb
    begin
        phase_step = phase_reg;
        cnt_next   = cnt_reg;
        err_next   = err_reg;
        type_next  = type_reg;
        nlen_next  = nlen_reg;
        dlen_next  = dlen_reg;
        stamp_next = stamp_reg;
        mode_next  = mode_reg;
        owner_next = owner_reg;
        group_next = group_reg;
        size_next  = size_reg;
        len_full   = {data_byte, cnt_reg[0] ? 8'h00 : 8'h00};
        rec        = 1'b0;

        unique case (phase_reg)
            PH_MAGIC:
            begin
                if (data_byte != magic_byte(cnt_reg[1:0]))
                begin
                    phase_step = PH_ERR;
                    err_next   = KIND_BAD_MAGIC;
                end
                else if (cnt_reg[1:0] == 2'd3)
                begin
                    phase_step = PH_TYPE;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 63'd1;
                end
            end
            PH_TYPE:
            begin
                type_next  = data_byte;
                nlen_next  = '0;
                dlen_next  = '0;
                stamp_next = '0;
                mode_next  = '0;
                owner_next = '0;
                group_next = '0;
                size_next  = '0;
                cnt_next   = '0;
                phase_step = PH_NLEN;
            end
            PH_NLEN, PH_DLEN:
            begin
                len_full = {data_byte, (phase_reg == PH_NLEN) ? nlen_reg[7:0] : dlen_reg[7:0]};
                if (!cnt_reg[0])
                begin
                    if (phase_reg == PH_NLEN)
                        nlen_next = {8'h00, data_byte};
                    else
                        dlen_next = {8'h00, data_byte};
                    cnt_next = 63'd1;
                end
                else
                begin
                    if (phase_reg == PH_NLEN)
                        nlen_next = len_full;
                    else
                        dlen_next = len_full;
                    cnt_next = {47'd0, len_full};
                    if (len_full != 16'd0)
                        phase_step = (phase_reg == PH_NLEN) ? PH_NAME : PH_DESC;
                    else
                        phase_step = (phase_reg == PH_NLEN) ? PH_DLEN : PH_FIXED;
                end
            end
            PH_NAME, PH_DESC:
            begin
                cnt_next = cnt_reg - 63'd1;
                if (cnt_reg == 63'd1)
                    phase_step = (phase_reg == PH_NAME) ? PH_DLEN : PH_FIXED;
            end
            PH_FIXED:
            begin
                if (fidx < MODE_BASE)
                    stamp_next[{fidx[2:0], 3'b000} +: 8] = data_byte;
                else if (fidx < OWNER_BASE)
                    mode_next[{fidx[0], 3'b000} +: 8] = data_byte;
                else if (fidx < GROUP_BASE)
                    owner_next[{fidx[0], 3'b000} +: 8] = data_byte;
                else if (fidx < SIZE_BASE)
                    group_next[{fidx[0], 3'b000} +: 8] = data_byte;
                else
                    size_next[{sidx[2:0], 3'b000} +: 8] = data_byte;
                cnt_next = cnt_reg + 63'd1;
                if (fidx == FIXED_LAST)
                begin
                    if (data_byte[7])
                    begin
                        phase_step = PH_ERR;
                        err_next   = KIND_NEG_SIZE;
                    end
                    else if (size_full == 64'd0)
                    begin
                        rec        = 1'b1;
                        phase_step = PH_TYPE;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        cnt_next   = size_full[62:0];
                        phase_step = PH_DATA;
                    end
                end
            end
            PH_DATA:
            begin
                cnt_next = cnt_reg - 63'd1;
                if (cnt_reg == 63'd1)
                begin
                    rec        = 1'b1;
                    phase_step = PH_TYPE;
                end
            end
            PH_ERR:
            begin
                phase_step = PH_ERR;
            end
            default:
            begin
                phase_step = PH_ERR;
            end
        endcase

        // End of image: classify where the parse stopped
        unique case (phase_step)
            PH_ERR:   end_kind = err_reg == KIND_RECORD ? err_next : err_next;
            PH_TYPE:  end_kind = KIND_CLEAN;
            PH_MAGIC: end_kind = KIND_BAD_MAGIC;
            default:  end_kind = KIND_TRUNC;
        endcase

        phase_next = phase_step;
        if (final_byte)
        begin
            phase_next = PH_MAGIC;
            cnt_next   = '0;
            err_next   = KIND_RECORD;
        end
    end

    always_comb
    begin
        rec_res            = '0;
        rec_res.kind       = KIND_RECORD;
        rec_res.entry_type = type_next;
        rec_res.name_len   = nlen_next;
        rec_res.desc_len   = dlen_next;
        rec_res.stamp      = stamp_next;
        rec_res.perm_mode  = mode_next;
        rec_res.owner_id   = owner_next;
        rec_res.group_id   = group_next;
        rec_res.data_size  = size_next[62:0];

        end_res      = '0;
        end_res.kind = end_kind;

        push.count  = accept ? ({1'b0, rec} + {1'b0, final_byte}) : 2'd0;
        push.first  = rec ? rec_res : end_res;
        push.second = end_res;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_MAGIC;
            cnt_reg   <= '0;
            err_reg   <= KIND_RECORD;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            err_reg   <= err_next;
        end
    end

    // Header fields; all but the type are cleared on every type byte
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            type_reg  <= type_next;
            nlen_reg  <= nlen_next;
            dlen_reg  <= dlen_next;
            stamp_reg <= stamp_next;
            mode_reg  <= mode_next;
            owner_reg <= owner_next;
            group_reg <= group_next;
            size_reg  <= size_next;
        end
    end

endmodule

// ----- rtl/core/arhp_fifo.sv -----
module arhp_fifo
    import arhp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  push_t        push,
    input  logic         pop,
    output result_t      head,
    output logic         head_valid,
    output fifo_status_t status
);

    result_t              mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_LW-1:0]   level_reg, level_next;
    logic [FIFO_AW-1:0]   wr_ptr_second;
    logic                 do_pop;

    assign do_pop        = pop && (level_reg != '0);
    assign wr_ptr_second = wr_ptr_reg + FIFO_AW'(1);
    assign wr_ptr_next   = wr_ptr_reg + FIFO_AW'(push.count);
    assign rd_ptr_next   = rd_ptr_reg + FIFO_AW'(do_pop);
    assign level_next    = level_reg + FIFO_LW'(push.count) - FIFO_LW'(do_pop);

    assign head        = mem[rd_ptr_reg];
    assign head_valid  = (level_reg != '0);
    assign status.level = level_reg;
    // Room for a full two-result beat
    assign status.room  = (level_reg <= FIFO_LW'(FIFO_DEPTH - 2));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            mem[wr_ptr_second] <= push.second;
    end

endmodule

// ----- rtl/core/archive_record_header_parser.sv -----
// A result beat is written into the result queue when the input byte that
// completes it is accepted; an end report follows its record.
// Throughput: one byte per cycle while in_ready is high; in_ready drops only
// while the result queue holds more than two beats.
// Reset (rst_n low, asynchronous) returns the parser to the magic check and
// empties the result queue. After each final byte the parser restarts itself.
`include "assert_macros.svh"

module archive_record_header_parser
    import arhp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         data_byte,
    input  logic               final_byte,

    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         kind,
    output logic [7:0]         entry_type,
    output logic [15:0]        name_len,
    output logic [15:0]        desc_len,
    output logic signed [63:0] stamp,
    output logic [15:0]        perm_mode,
    output logic [15:0]        owner_id,
    output logic [15:0]        group_id,
    output logic [62:0]        data_size
);

    logic         accept;
    push_t        push;
    result_t      head;
    fifo_status_t fifo_stat;

    // Take a beat only when the queue can absorb a record plus an end report
    assign in_ready = fifo_stat.room;
    assign accept   = in_valid && in_ready;

    // Byte-level parser: phase, counters and header field assembly
    arhp_parse u_parse
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .push       (push)
    );

    // Result queue decouples the output handshake from the byte stream
    arhp_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (out_ready),
        .head       (head),
        .head_valid (out_valid),
        .status     (fifo_stat)
    );

    assign kind       = head.kind;
    assign entry_type = head.entry_type;
    assign name_len   = head.name_len;
    assign desc_len   = head.desc_len;
    assign stamp      = head.stamp;
    assign perm_mode  = head.perm_mode;
    assign owner_id   = head.owner_id;
    assign group_id   = head.group_id;
    assign data_size  = head.data_size;

    `AST_CHECK(a_level_bound, fifo_stat.level <= FIFO_LW'(FIFO_DEPTH), "result queue overflow")
    `AST_IMPLY(a_ready_room, in_ready, fifo_stat.level <= FIFO_LW'(FIFO_DEPTH - 2), "ready without room for two beats")
    `AST_IMPLY(a_end_clean, out_valid && (kind != KIND_RECORD), (data_size == '0) && (stamp == '0) && (name_len == '0) && (entry_type == '0), "end report carries header fields")
    `AST_NEXT(a_final_report, in_valid && in_ready && final_byte, out_valid, "final byte left no report")

endmodule
